@@ sv/lrupr_pkg.sv @@
// Types and constants shared by the LRU page replacement block.
// No dependencies; compiled first.
package lrupr_pkg;

  localparam int FIU_W     = 5;
  localparam int OUTCOME_W = 2;
  localparam int SLOT_W    = 4;
  localparam int FAULT_W   = 32;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [FIU_W-1:0] FRAMES_RESET = 5'd16;
  localparam logic             FILL_RESET   = 1'b1;

  typedef enum logic [OUTCOME_W-1:0] {
    OC_HIT   = 2'd0,
    OC_FILL  = 2'd1,
    OC_EVICT = 2'd2
  } outcome_e;

  typedef enum logic [0:0] {
    REG_FRAMES = 1'b0,
    REG_FILL   = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [FIU_W-1:0] frames_in_use;
    logic             count_fill_faults;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic decide;
    logic update;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic pass_done;
    logic out_free;
  } sts_t;

endpackage

@@ sv/lrupr_in_if.sv @@
// Page reference channel: valid/ready handshake with one page number.
// No dependencies.
interface lrupr_in_if #(
  parameter int PAGE_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

@@ sv/lrupr_out_if.sv @@
// Result channel: valid/ready handshake with outcome, frame and fault count.
// Depends on lrupr_pkg.
interface lrupr_out_if
  import lrupr_pkg::*;
#(
  parameter int PAGE_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [OUTCOME_W-1:0] outcome;
  logic [SLOT_W-1:0]    frame_slot;
  logic                 evicted_valid;
  logic [PAGE_BITS-1:0] evicted_page;
  logic [FAULT_W-1:0]   fault_total;

  modport source (output valid, output outcome, output frame_slot, output evicted_valid,
                  output evicted_page, output fault_total, input ready);
  modport sink   (input valid, input outcome, input frame_slot, input evicted_valid,
                  input evicted_page, input fault_total, output ready);
endinterface

@@ sv/lrupr_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lrupr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ sv/lrupr_ctrl.sv @@
// Sequencer for one page reference: scan pass, decision, update pass, result.
// Depends on lrupr_pkg.
module lrupr_ctrl
  import lrupr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN:   if (sts_i.pass_done) state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_UPDATE;
      ST_UPDATE: if (sts_i.pass_done) state_d = ST_FINISH;
      ST_FINISH: if (sts_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SCAN:   cmd_o.scan   = 1'b1;
      ST_DECIDE: cmd_o.decide = 1'b1;
      ST_UPDATE: cmd_o.update = 1'b1;
      ST_FINISH: cmd_o.commit = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

@@ sv/lrupr_dp.sv @@
// Datapath: frame table RAM, valid marks, search registers, fault counter
// and result register. Depends on lrupr_pkg and lrupr_ram.
module lrupr_dp
  import lrupr_pkg::*;
#(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  cfg_t                 cfg_i,
  input  logic [PAGE_BITS-1:0] page_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [OUTCOME_W-1:0] outcome_o,
  output logic [SLOT_W-1:0]    frame_slot_o,
  output logic                 evicted_valid_o,
  output logic [PAGE_BITS-1:0] evicted_page_o,
  output logic [FAULT_W-1:0]   fault_total_o
);

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int AGE_W = IDX_W;
  localparam int WORD_W = AGE_W + PAGE_BITS;
  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(FRAMES - 1);

  logic [CNT_W-1:0] n_act;
  always_comb begin
    if (cfg_i.frames_in_use == '0) begin
      n_act = CNT_W'(1);
    end else if (32'(cfg_i.frames_in_use) > 32'(FRAMES)) begin
      n_act = CNT_W'(FRAMES);
    end else begin
      n_act = CNT_W'(cfg_i.frames_in_use);
    end
  end

  logic [PAGE_BITS-1:0] page_q;
  logic [CNT_W-1:0]     rd_idx_q, rd_idx_d;
  logic                 pipe_v_q;
  logic [IDX_W-1:0]     pipe_idx_q;
  logic [FRAMES-1:0]    valid_q, valid_d;

  logic                 hit_q, hit_d, free_q, free_d;
  logic [IDX_W-1:0]     hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  logic [AGE_W-1:0]     hit_age_q, hit_age_d, best_age_q, best_age_d;
  logic [IDX_W-1:0]     best_idx_q, best_idx_d;
  logic [PAGE_BITS-1:0] best_page_q, best_page_d;

  logic [IDX_W-1:0]     slot_q;
  outcome_e             oc_q;
  logic [PAGE_BITS-1:0] evp_q;
  logic [FAULT_W-1:0]   fault_q;

  logic                 out_valid_q;
  outcome_e             out_oc_q;
  logic [IDX_W-1:0]     out_slot_q;
  logic                 out_evv_q;
  logic [PAGE_BITS-1:0] out_evp_q;
  logic [FAULT_W-1:0]   out_fault_q;

  logic                 rd_go;
  logic [WORD_W-1:0]    rdata, wdata;
  logic [AGE_W-1:0]     rd_age, age_new;
  logic [PAGE_BITS-1:0] rd_page;
  logic                 rd_valid, we;

  assign rd_go    = (cmd_i.scan || cmd_i.update) && (rd_idx_q < n_act);
  assign rd_idx_d = (cmd_i.load || cmd_i.decide) ? '0 :
                    (rd_go ? rd_idx_q + CNT_W'(1) : rd_idx_q);
  assign rd_age   = rdata[WORD_W-1:PAGE_BITS];
  assign rd_page  = rdata[PAGE_BITS-1:0];
  assign rd_valid = valid_q[pipe_idx_q];

  assign sts_o.pass_done = !(rd_idx_q < n_act) && !pipe_v_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  lrupr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (FRAMES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (pipe_idx_q),
    .wdata_i (wdata),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  // scan pass: first hit, first empty frame, oldest frame
  always_comb begin
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_age_d   = hit_age_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    best_age_d  = best_age_q;
    best_idx_d  = best_idx_q;
    best_page_d = best_page_q;
    if (cmd_i.load) begin
      hit_d  = 1'b0;
      free_d = 1'b0;
    end else if (cmd_i.scan && pipe_v_q) begin
      if (rd_valid && (rd_page == page_q) && !hit_q) begin
        hit_d     = 1'b1;
        hit_idx_d = pipe_idx_q;
        hit_age_d = rd_age;
      end
      if (!rd_valid && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = pipe_idx_q;
      end
      if ((pipe_idx_q == '0) || (rd_age > best_age_q)) begin
        best_age_d  = rd_age;
        best_idx_d  = pipe_idx_q;
        best_page_d = rd_page;
      end
    end
  end

  // update pass: refresh ranks, write new page into the chosen frame
  always_comb begin
    we      = cmd_i.update && pipe_v_q;
    age_new = rd_age;
    if (rd_valid && ((oc_q != OC_HIT) || (rd_age < hit_age_q)) && (rd_age < AGE_MAX)) begin
      age_new = rd_age + AGE_W'(1);
    end
    if (pipe_idx_q == slot_q) begin
      wdata = {AGE_W'(0), (oc_q == OC_HIT) ? rd_page : page_q};
    end else begin
      wdata = {age_new, rd_page};
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.decide && !hit_q && free_q) begin
      valid_d[free_idx_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q    <= '0;
      pipe_v_q    <= 1'b0;
      valid_q     <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      oc_q        <= OC_HIT;
      fault_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_idx_q <= rd_idx_d;
      pipe_v_q <= rd_go;
      valid_q  <= valid_d;
      hit_q    <= hit_d;
      free_q   <= free_d;
      if (cmd_i.decide) begin
        if (hit_q) begin
          oc_q <= OC_HIT;
        end else if (free_q) begin
          oc_q <= OC_FILL;
          if (cfg_i.count_fill_faults && (fault_q != '1)) begin
            fault_q <= fault_q + FAULT_W'(1);
          end
        end else begin
          oc_q <= OC_EVICT;
          if (fault_q != '1) begin
            fault_q <= fault_q + FAULT_W'(1);
          end
        end
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_idx_q  <= rd_idx_q[IDX_W-1:0];
    hit_idx_q   <= hit_idx_d;
    hit_age_q   <= hit_age_d;
    free_idx_q  <= free_idx_d;
    best_age_q  <= best_age_d;
    best_idx_q  <= best_idx_d;
    best_page_q <= best_page_d;
    if (cmd_i.load) begin
      page_q <= page_i;
    end
    if (cmd_i.decide) begin
      if (hit_q) begin
        slot_q <= hit_idx_q;
        evp_q  <= '0;
      end else if (free_q) begin
        slot_q <= free_idx_q;
        evp_q  <= '0;
      end else begin
        slot_q <= best_idx_q;
        evp_q  <= best_page_q;
      end
    end
    if (cmd_i.commit) begin
      out_oc_q    <= oc_q;
      out_slot_q  <= slot_q;
      out_evv_q   <= (oc_q == OC_EVICT);
      out_evp_q   <= evp_q;
      out_fault_q <= fault_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign outcome_o       = out_oc_q;
  assign frame_slot_o    = SLOT_W'(out_slot_q);
  assign evicted_valid_o = out_evv_q;
  assign evicted_page_o  = out_evp_q;
  assign fault_total_o   = out_fault_q;

endmodule

@@ sv/lru_page_replacement.sv @@
// Top level of the LRU page replacement block: register port and instances.
// Depends on lrupr_pkg, lrupr_in_if, lrupr_out_if, lrupr_ctrl and lrupr_dp.
//
// Usage: one page reference enters per transaction on in_i (valid/ready);
// one result leaves per reference on out_o (valid/ready): outcome, frame
// used, evicted page and running fault count. Two registers sit on the APB
// port: frames_in_use at 0x0 and count_fill_faults at 0x4; write them only
// while the block is idle.
// Sequence: with n active frames, each accepted reference runs one scan pass
// and one rank update pass over the n frames through the frame table RAM
// (one read and one write port), with a decision step between them and a
// result step after them, before the next reference is accepted.
// Reset clears all valid marks, the fault count and the state machine, and
// loads the registers with 16 frames and fill faults counted.
// Stall: a result waits in the output register while the next reference is
// taken and processed; that reference finishes once the register frees.
module lru_page_replacement
  import lrupr_pkg::*;
#(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  lrupr_in_if.sink           in_i,
  lrupr_out_if.source        out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     cfg_wr;
  cmd_t     cmd;
  sts_t     sts;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frames_in_use     <= FRAMES_RESET;
      cfg_q.count_fill_faults <= FILL_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FRAMES: cfg_q.frames_in_use     <= pwdata[FIU_W-1:0];
        REG_FILL:   cfg_q.count_fill_faults <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAMES: prdata = APB_DW'(cfg_q.frames_in_use);
      REG_FILL:   prdata = APB_DW'(cfg_q.count_fill_faults);
      default:    prdata = '0;
    endcase
  end

  lrupr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lrupr_dp #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_i           (cfg_q),
    .page_i          (in_i.page_number),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .outcome_o       (out_o.outcome),
    .frame_slot_o    (out_o.frame_slot),
    .evicted_valid_o (out_o.evicted_valid),
    .evicted_page_o  (out_o.evicted_page),
    .fault_total_o   (out_o.fault_total)
  );

endmodule

@@ tb/lru_page_replacement_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for lru_page_replacement: drives page references and APB
// register writes, predicts each hit/fill/evict result with an exact LRU model.
// Depends on lrupr_pkg, lrupr_in_if, lrupr_out_if and the block's RTL.
module lru_page_replacement_tb;
  import lrupr_pkg::*;

  localparam int HALF_PERIOD     = 10;
  localparam int RESET_CYCLES    = 10;
  localparam int NUM_FRAMES      = 16;
  localparam int PAGE_W          = 16;
  localparam int AGE_TOP         = NUM_FRAMES - 1;
  localparam int DRAIN_CYCLES    = 2 * NUM_FRAMES + 12;
  localparam int STALL_LIMIT     = 4000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_AT     = 140;
  localparam int PHASES          = 8;
  localparam int REFS_PER_PHASE  = 75;
  localparam int POOL_SIZE       = 32;

  typedef struct packed {
    outcome_e           outcome;
    logic [SLOT_W-1:0]  frame_slot;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [FAULT_W-1:0] fault_total;
  } lru_res_t;

  typedef enum logic {ROW_REF, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    reg_idx_e          reg_sel;
    logic [PAGE_W-1:0] data;
    logic              typed;
    lru_res_t          want;
  } stim_row_t;

  localparam lru_res_t NO_RES = '{OC_HIT, 4'd0, 1'b0, 16'h0000, 32'd0};

  localparam int DIRECTED_ROWS = 22;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_REF, REG_FRAMES, 16'h0000, 1'b1, '{OC_FILL, 4'd0, 1'b0, 16'h0000, 32'd1}},
    '{ROW_REF, REG_FRAMES, 16'hFFFF, 1'b1, '{OC_FILL, 4'd1, 1'b0, 16'h0000, 32'd2}},
    '{ROW_REF, REG_FRAMES, 16'h0000, 1'b1, '{OC_HIT, 4'd0, 1'b0, 16'h0000, 32'd2}},
    '{ROW_REF, REG_FRAMES, 16'h8001, 1'b0, NO_RES},
    '{ROW_CFG, REG_FRAMES, 16'd2, 1'b0, NO_RES},
    '{ROW_REF, REG_FRAMES, 16'h8001, 1'b0, NO_RES},
    '{ROW_REF, REG_FRAMES, 16'h7FFE, 1'b0, NO_RES},
    '{ROW_REF, REG_FRAMES, 16'h8001, 1'b0, NO_RES},
    '{ROW_CFG, REG_FRAMES, 16'd0, 1'b0, NO_RES},
    '{ROW_REF, REG_FRAMES, 16'h1234, 1'b0, NO_RES},
    '{ROW_REF, REG_FRAMES, 16'h1234, 1'b0, NO_RES},
    '{ROW_CFG, REG_FILL, 16'd0, 1'b0, NO_RES},
    '{ROW_CFG, REG_FRAMES, 16'd31, 1'b0, NO_RES},
    '{ROW_REF, REG_FRAMES, 16'h8001, 1'b0, NO_RES},
    '{ROW_REF, REG_FRAMES, 16'h4321, 1'b0, NO_RES},
    '{ROW_REF, REG_FRAMES, 16'hFFFF, 1'b0, NO_RES},
    '{ROW_CFG, REG_FRAMES, 16'd17, 1'b0, NO_RES},
    '{ROW_REF, REG_FRAMES, 16'hAAAA, 1'b0, NO_RES},
    '{ROW_REF, REG_FRAMES, 16'h5555, 1'b0, NO_RES},
    '{ROW_REF, REG_FRAMES, 16'h0000, 1'b0, NO_RES},
    '{ROW_CFG, REG_FILL, 16'd1, 1'b0, NO_RES},
    '{ROW_CFG, REG_FRAMES, 16'd16, 1'b0, NO_RES}
  };

  localparam logic [FIU_W-1:0] FRAME_PLAN [PHASES] = '{
    5'd16, 5'd1, 5'd4, 5'd31, 5'd0, 5'd17, 5'd9, 5'd16
  };
  localparam logic FILL_PLAN [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  lrupr_in_if  #(.PAGE_BITS(PAGE_W)) in_if ();
  lrupr_out_if #(.PAGE_BITS(PAGE_W)) out_if ();

  lru_page_replacement #(
    .FRAMES    (NUM_FRAMES),
    .PAGE_BITS (PAGE_W)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [FIU_W-1:0]   cfg_frames = FRAMES_RESET;
  logic               cfg_fill = FILL_RESET;
  logic [PAGE_W-1:0]  frame_page [NUM_FRAMES];
  logic               frame_valid [NUM_FRAMES] = '{default: 1'b0};
  logic [3:0]         frame_age [NUM_FRAMES] = '{default: 4'd0};
  logic [FAULT_W-1:0] fault_count = '0;
  lru_res_t           expected_q [$];
  logic [PAGE_W-1:0]  page_pool [POOL_SIZE];
  int                 mismatches = 0;
  int                 results_seen = 0;
  int                 quiet_cycles = 0;
  bit                 tx_quiet = 1'b0;
  bit                 rx_quiet = 1'b0;

  always #HALF_PERIOD clk_i = ~clk_i;

  function automatic int active_frames();
    if (cfg_frames == 0) return 1;
    if (cfg_frames > NUM_FRAMES) return NUM_FRAMES;
    return int'(cfg_frames);
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic void age_frames(input int n, input int f, input int limit);
    for (int k = 0; k < n; k++) begin
      if (k != f && frame_valid[k] && frame_age[k] < limit && frame_age[k] < AGE_TOP) begin
        frame_age[k] = frame_age[k] + 4'd1;
      end
    end
    frame_age[f] = 4'd0;
  endfunction

  function automatic void count_fault();
    if (fault_count != '1) fault_count = fault_count + 1'b1;
  endfunction

  function automatic lru_res_t lru_lookup(input logic [PAGE_W-1:0] pg);
    lru_res_t r;
    int       n;
    int       f;
    int       best;
    r = NO_RES;
    n = active_frames();
    f = -1;
    for (int k = 0; k < n; k++) begin
      if (f < 0 && frame_valid[k] && frame_page[k] == pg) f = k;
    end
    if (f >= 0) begin
      r.outcome = OC_HIT;
      age_frames(n, f, int'(frame_age[f]));
    end else begin
      for (int k = 0; k < n; k++) begin
        if (f < 0 && !frame_valid[k]) f = k;
      end
      if (f >= 0) begin
        r.outcome      = OC_FILL;
        frame_page[f]  = pg;
        frame_valid[f] = 1'b1;
        age_frames(n, f, NUM_FRAMES + 1);
        if (cfg_fill) count_fault();
      end else begin
        best = 0;
        f    = 0;
        for (int k = 0; k < n; k++) begin
          if (int'(frame_age[k]) > best) begin
            best = int'(frame_age[k]);
            f    = k;
          end
        end
        r.outcome       = OC_EVICT;
        r.evicted_valid = 1'b1;
        r.evicted_page  = frame_page[f];
        frame_page[f]   = pg;
        age_frames(n, f, NUM_FRAMES + 1);
        count_fault();
      end
    end
    r.frame_slot  = SLOT_W'(f);
    r.fault_total = fault_count;
    return r;
  endfunction

  task automatic offer_page(input logic [PAGE_W-1:0] pg, input logic typed,
                            input lru_res_t want);
    lru_res_t predicted;
    int       gap;
    in_if.valid       <= 1'b1;
    in_if.page_number <= pg;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predicted = lru_lookup(pg);
    expected_q.push_back(typed ? want : predicted);
    gap = tx_quiet ? 0 : gap_len();
    if (gap > 0) begin
      in_if.valid       <= 1'b0;
      in_if.page_number <= PAGE_W'($urandom());
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(input reg_idx_e idx, input logic [APB_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == REG_FRAMES) cfg_frames = val[FIU_W-1:0];
    else cfg_fill = val[0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    mismatches++;
  endtask

  task automatic check_result();
    lru_res_t want;
    results_seen++;
    if (expected_q.size() == 0) begin
      $display("%0t: result with none expected, expected nothing, actual outcome %0d slot %0d",
               $time, out_if.outcome, out_if.frame_slot);
      mismatches++;
      return;
    end
    want = expected_q.pop_front();
    if (out_if.outcome !== want.outcome)
      report_field("outcome", 32'(want.outcome), 32'(out_if.outcome));
    if (out_if.frame_slot !== want.frame_slot)
      report_field("frame_slot", 32'(want.frame_slot), 32'(out_if.frame_slot));
    if (out_if.evicted_valid !== want.evicted_valid)
      report_field("evicted_valid", 32'(want.evicted_valid), 32'(out_if.evicted_valid));
    if (out_if.evicted_page !== want.evicted_page)
      report_field("evicted_page", 32'(want.evicted_page), 32'(out_if.evicted_page));
    if (out_if.fault_total !== want.fault_total)
      report_field("fault_total", want.fault_total, out_if.fault_total);
  endtask

  initial begin : result_sink
    int rx_wait;
    bit held;
    rx_wait = 0;
    held    = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) check_result();
      if (rx_wait > 0) begin
        rx_wait--;
      end else if (!held && results_seen >= HOLD_OFF_AT) begin
        held    = 1'b1;
        rx_wait = HOLD_OFF_CYCLES;
      end else if (!rx_quiet && $urandom_range(0, 5) == 0) begin
        rx_wait = gap_len();
      end
      out_if.ready <= (rx_wait == 0);
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("lru_page_replacement test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : page_source
    logic [PAGE_W-1:0] pg;
    logic [FIU_W-1:0]  fv;
    int                span;
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.page_number <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    for (int i = 0; i < POOL_SIZE; i++) page_pool[i] = PAGE_W'($urandom());
    page_pool[0] = '0;
    page_pool[1] = '1;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        wait_idle();
        reg_write(DIRECTED[r].reg_sel, APB_DW'(DIRECTED[r].data));
      end else begin
        offer_page(DIRECTED[r].data, DIRECTED[r].typed, DIRECTED[r].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      fv = (ph == 6) ? FIU_W'($urandom_range(1, NUM_FRAMES)) : FRAME_PLAN[ph];
      reg_write(REG_FRAMES, ($urandom() << FIU_W) | APB_DW'(fv));
      reg_write(REG_FILL, ($urandom() << 1) | APB_DW'(FILL_PLAN[ph]));
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      span = active_frames() + $urandom_range(0, 4);
      for (int i = 0; i < REFS_PER_PHASE; i++) begin
        if ($urandom_range(0, 9) < 8) pg = page_pool[$urandom_range(0, span - 1)];
        else pg = PAGE_W'($urandom());
        offer_page(pg, 1'b0, NO_RES);
      end
    end

    wait_idle();
    if (mismatches == 0) $display("lru_page_replacement test passed");
    else $display("lru_page_replacement test failed");
    $finish;
  end

endmodule

@@ files.f @@
sv/lrupr_pkg.sv
sv/lrupr_in_if.sv
sv/lrupr_out_if.sv
sv/lrupr_ram.sv
sv/lrupr_ctrl.sv
sv/lrupr_dp.sv
sv/lru_page_replacement.sv
tb/lru_page_replacement_tb.sv
